### rtl/core/graph_adjacency_table_assert.svh
// Assertion macros for the graph adjacency table RTL.
`ifndef GRAPH_ADJACENCY_TABLE_ASSERT_SVH
`define GRAPH_ADJACENCY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is held.
`define GAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/gat_pkg.sv
// Shared types and constants for the graph adjacency table.
`default_nettype none

package gat_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_DEGREE   = 16;

    localparam int VTX_W     = 8;                        // vertex field width
    localparam int LABEL_W   = 8;
    localparam int IDX_W     = $clog2(MAX_DEGREE);       // slot index within a row
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);   // degree value incl. full row
    localparam int ROW_W     = $clog2(MAX_VERTICES);     // row select bits
    localparam int EDGE_AW   = ROW_W + IDX_W;
    localparam int EDGE_DW   = VTX_W + LABEL_W;
    localparam int VCOUNT_W  = 9;
    localparam int TOTAL_W   = 13;
    localparam int OUTDEG_W  = 5;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
    localparam logic [DEG_W-1:0]   DEG_FULL   = DEG_W'(MAX_DEGREE);
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(MAX_VERTICES);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD        = 2'd0,
        MODE_EDGE_QUERY = 2'd1,
        MODE_DEG_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEG_RD,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } t_state;

    // Write request into the degree table.
    typedef struct packed {
        logic               en;
        logic [ROW_W-1:0]   addr;
        logic [DEG_W-1:0]   data;
    } t_deg_wr;

endpackage

`default_nettype wire

### rtl/core/graph_adjacency_table.sv
// Top level of the graph adjacency table: directed-graph edge store.
//
//  Channel   Dir  Handshake                 Payload
//  s (item)  in   i_s_tvalid / o_s_tready   tdata: source, sink, label; tuser: mode
//  m (res)   out  o_m_tvalid / i_m_tready   tdata: found, label, degree, total; tuser: status
//  cfg       in   i_cfg_valid / o_cfg_ready vertex_count (9 bits)
//
//  An add or edge query scans the source row, whose degree is 16 at most; a hit in a
//  slot ends the scan early. The row is scanned one slot per cycle through the single
//  edge memory read port; degree queries and out-of-range items skip the scan. The next
//  beat is taken no earlier than the cycle after the result is parked, so items never
//  overlap. Reset is synchronous: degree counts clear at once through valid bits, the
//  edge memory needs no clearing pass. A stalled output only holds the finishing step.
`default_nettype none
`include "graph_adjacency_table_assert.svh"

module graph_adjacency_table import gat_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Item channel
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [23:0]          i_s_tdata,   // [7:0] source_vertex, [15:8] sink_vertex,
                                                   // [23:16] edge_label
    input  wire logic [MODE_W-1:0]    i_s_tuser,   // [1:0] mode
    // Result channel
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [31:0]               o_m_tdata,   // [0] edge_found, [8:1] found_label,
                                                   // [13:9] out_degree, [26:14] edge_total,
                                                   // [31:27] zero
    output logic [STATUS_W-1:0]       o_m_tuser,   // [1:0] status
    // Configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [VCOUNT_W-1:0]  i_cfg_data
);

    t_state                  r_state, n_state;

    // Item held for the duration of its work
    logic [MODE_W-1:0]       r_mode;
    logic [VTX_W-1:0]        r_src;
    logic [VTX_W-1:0]        r_snk;
    logic [LABEL_W-1:0]      r_lab;

    logic [DEG_W-1:0]        r_deg;
    logic [DEG_W-1:0]        r_idx;
    logic                    r_rd_pend;
    logic                    r_found;
    logic [LABEL_W-1:0]      r_flabel;
    logic                    r_oor;

    logic [VCOUNT_W-1:0]     r_vcount;
    logic [TOTAL_W-1:0]      r_total, n_total;

    logic                    r_out_valid;
    logic [31:0]             r_out_tdata;
    logic [STATUS_W-1:0]     r_out_tuser;

    // Edge memory: sink in the low byte, label in the high byte
    logic [EDGE_DW-1:0]      r_edge_mem [0:MAX_VERTICES*MAX_DEGREE-1];
    logic [EDGE_DW-1:0]      r_edge_q;
    logic [EDGE_AW-1:0]      w_edge_raddr;
    logic [EDGE_AW-1:0]      w_edge_waddr;
    logic                    w_edge_we;

    logic [DEG_W-1:0]        w_deg_q;
    t_deg_wr                 w_deg_wr;

    logic                    w_accept;
    logic                    w_adv;
    logic                    w_edge_op;
    logic                    w_src_ok;
    logic                    w_snk_ok;
    logic                    w_hit;
    logic                    w_more;
    logic                    w_new;
    logic                    w_full;
    logic [DEG_W-1:0]        w_deg_inc;
    logic [OUTDEG_W-1:0]     w_out_deg;
    t_status                 w_status;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_adv       = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_tdata;
    assign o_m_tuser   = r_out_tuser;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign w_edge_op = (r_mode == MODE_ADD) || (r_mode == MODE_EDGE_QUERY);
    assign w_src_ok  = {1'b0, r_src} < r_vcount;
    assign w_snk_ok  = {1'b0, r_snk} < r_vcount;

    // Compare the slot read last cycle; issue the next while slots remain
    assign w_hit  = r_rd_pend && (r_edge_q[VTX_W-1:0] == r_snk);
    assign w_more = r_idx < r_deg;

    assign w_new     = w_edge_op && !r_oor && (r_mode == MODE_ADD) && !r_found;
    assign w_full    = r_deg >= DEG_FULL;
    assign w_deg_inc = r_deg + DEG_W'(1);

    assign w_edge_raddr = {r_src, r_idx[IDX_W-1:0]};
    assign w_edge_waddr = {r_src, r_deg[IDX_W-1:0]};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DEG_RD;
                end
            end
            S_DEG_RD: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_edge_op && w_src_ok && w_snk_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (w_hit || !w_more) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_adv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State-driven outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        w_edge_we  = 1'b0;
        w_deg_wr   = '{en: 1'b0, addr: r_src, data: w_deg_inc};
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_FINISH: begin
                w_edge_we   = w_adv && w_new && !w_full;
                w_deg_wr.en = w_adv && w_new && !w_full;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    always_comb begin
        if (r_oor) begin
            w_status = ST_RANGE;
        end else if (w_new && w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_DONE;
        end

        if (r_oor) begin
            w_out_deg = '0;
        end else if (w_new && !w_full) begin
            w_out_deg = OUTDEG_W'(w_deg_inc);
        end else begin
            w_out_deg = OUTDEG_W'(r_deg);
        end

        // Saturate the running total
        if (w_edge_we && (r_total != TOTAL_MAX)) begin
            n_total = r_total + TOTAL_W'(1);
        end else begin
            n_total = r_total;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            r_edge_mem[w_edge_waddr] <= {r_lab, r_snk};
        end
        r_edge_q <= r_edge_mem[w_edge_raddr];
    end

    gat_degree_table u_degree (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_src),
        .o_rd_data (w_deg_q),
        .i_wr      (w_deg_wr)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VCOUNT_RST;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            if (r_state == S_FINISH && w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // Track whether the edge read data belongs to a live slot
            if (r_state == S_SCAN && !w_hit && w_more) begin
                r_rd_pend <= 1'b1;
            end else begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_s_tuser;
            r_src  <= i_s_tdata[7:0];
            r_snk  <= i_s_tdata[15:8];
            r_lab  <= i_s_tdata[23:16];
        end

        case (r_state)
            S_CHECK: begin
                r_deg    <= w_deg_q;
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_flabel <= '0;
                r_oor    <= w_edge_op ? !(w_src_ok && w_snk_ok) : !w_src_ok;
            end
            S_SCAN: begin
                if (w_hit) begin
                    r_found  <= 1'b1;
                    r_flabel <= r_edge_q[EDGE_DW-1:VTX_W];
                end else if (w_more) begin
                    r_idx <= r_idx + DEG_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (r_state == S_FINISH && w_adv) begin
            r_out_tdata <= {5'd0, n_total, w_out_deg, r_flabel, r_found};
            r_out_tuser <= w_status;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GAT_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= r_deg,
                    "scan index passed the row degree")
    `GAT_ASSERT_IMP(a_write_fits, i_clk, i_rst_n, w_edge_we,
                    (r_deg < DEG_FULL) && !r_found && !r_oor,
                    "edge written into a full row or for a duplicate or an invalid vertex")
    `GAT_ASSERT_IMP(a_total_step, i_clk, i_rst_n,
                    $past(i_rst_n) && (r_total != $past(r_total)),
                    r_total == $past(r_total) + TOTAL_W'(1),
                    "edge total moved by more than one")
    `GAT_ASSERT_NXT(a_finish_load, i_clk, i_rst_n, (r_state == S_FINISH) && w_adv,
                    r_out_valid && (r_state == S_IDLE),
                    "finished item did not load the output register")

endmodule

`default_nettype wire

### rtl/core/gat_degree_table.sv
// Per-vertex out-degree memory with reset-cleared valid bits.
`default_nettype none

module gat_degree_table import gat_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [ROW_W-1:0] i_rd_addr,
    output logic [DEG_W-1:0]      o_rd_data,
    input  wire t_deg_wr          i_wr
);

    logic [DEG_W-1:0]        r_mem [0:MAX_VERTICES-1];
    logic [MAX_VERTICES-1:0] r_valid;
    logic [DEG_W-1:0]        r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // An entry never written reads as zero degree.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire
